[rtl/core/bfm_pkg.sv]
package bfm_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_LEVEL    = 7;
    localparam int MAX_CHANNELS = 4;
    localparam int HEIGHT_LIMIT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);      // column position / line store address
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT);   // row position
    localparam int DIM_W  = 13;                     // width / height registers
    localparam int LVL_W  = 3;
    localparam int NCH_W  = 3;
    localparam int FACT_W = MAX_LEVEL + 1;          // holds 2^MAX_LEVEL
    localparam int QW     = 8;                      // quotient bits, average fits a byte
    localparam int SUM_W  = QW + 2 * MAX_LEVEL;     // block sum
    localparam int DIV_W  = 2 * FACT_W;             // bw * br
    localparam int CNT_W  = $clog2(QW);

    typedef enum logic [1:0] {
        CFG_LEVEL  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_NCH    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
        logic [7:0] chan3;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] avg0;
        logic [7:0] avg1;
        logic [7:0] avg2;
        logic [7:0] avg3;
        logic       frame_end;
        logic       width_error;
    } t_pix_out;

    // control shared by all channel lanes
    typedef struct packed {
        logic [COL_W-1:0] addr;
        logic             wr;
        logic             first;
        logic             step;
        logic [SUM_W-1:0] dsh;
    } t_lane_ctl;

endpackage

[rtl/core/box_filter_mip_downsampler.sv]
// Channel     Direction  Handshake            Word
// config      in         i_cfg_we             i_cfg_idx, i_cfg_data
// source pix  in         i_valid / o_stall    i_pix  (chan0..chan3)
// reduced pix out        o_valid / i_stall    o_res  (avg0..avg3, flags)
//
// A leftover word (past the last whole block column or band) only moves the position.
// A block word that yields no result is accepted, then the line store does its
// read-add-write. The last word of a block adds the same way, then goes through
// an 8-step restoring divider per lane, then the load into the output register.
// Reset (synchronous, active low) restores the register defaults and the position;
// the line store needs no clearing, every sum is written at its band start.
// A stalled result sits in the output register while the next words are taken;
// only a second finished block waits for it.
module box_filter_mip_downsampler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  bfm_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [bfm_pkg::DIM_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  bfm_pkg::t_pix_in           i_pix,
    output logic                       o_valid,
    input  logic                       i_stall,
    output bfm_pkg::t_pix_out          o_res
);
    import bfm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // waiting for a source word
        S_ADD  = 4'b0010,   // line store data back, add and write
        S_DIV  = 4'b0100,   // lanes divide the block sums
        S_PUSH = 4'b1000    // hand averages to the output register
    } t_state;

    // configuration
    logic [LVL_W-1:0] r_level;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [NCH_W-1:0] r_nch;

    // frame position and control
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;

    // item held while it is worked on
    logic [COL_W-1:0] r_oc;
    logic             r_first;
    logic             r_last;
    logic             r_fend;
    logic             r_narrow;
    logic [SUM_W-1:0] r_dsh;
    t_pix_in          r_pix;

    // saturated settings
    logic [LVL_W-1:0]  lvl;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [NCH_W-1:0]  nch;
    logic [FACT_W-1:0] factor;
    logic [DIM_W-1:0]  factor_x;
    logic [DIM_W-1:0]  mask_x;
    logic              narrow;
    logic              short_img;
    logic [FACT_W-1:0] bw;
    logic [FACT_W-1:0] br;
    logic [DIM_W-1:0]  ow;
    logic [DIM_W-1:0]  oh;
    logic [DIM_W-1:0]  w_sh;
    logic [DIM_W-1:0]  h_sh;

    // position within the block grid
    logic [DIM_W-1:0]  col_x;
    logic [DIM_W-1:0]  row_x;
    logic [DIM_W-1:0]  oc;
    logic [DIM_W-1:0]  c;
    logic [DIM_W-1:0]  band;
    logic [DIM_W-1:0]  r;
    logic              in_block;
    logic              blk_first;
    logic              blk_last;
    logic              blk_fend;
    logic [DIV_W-1:0]  div;
    logic [DIM_W-1:0]  col_inc;
    logic [DIM_W-1:0]  row_inc;

    logic       accept;
    logic       push_ready;
    logic       push_load;
    t_lane_ctl  ctl;
    logic [7:0] pix_bytes [4];
    logic [7:0] q_all [4];

    always_comb begin
        lvl = (r_level > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : r_level;
        w   = (r_width == '0) ? DIM_W'(1) :
              ((r_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_width);
        h   = (r_height == '0) ? DIM_W'(1) :
              ((r_height > DIM_W'(HEIGHT_LIMIT)) ? DIM_W'(HEIGHT_LIMIT) : r_height);
        nch = (r_nch == '0) ? NCH_W'(1) :
              ((r_nch > NCH_W'(MAX_CHANNELS)) ? NCH_W'(MAX_CHANNELS) : r_nch);

        factor    = FACT_W'(1) << lvl;
        factor_x  = DIM_W'(factor);
        mask_x    = factor_x - DIM_W'(1);
        narrow    = w < factor_x;
        short_img = h < factor_x;
        bw        = narrow ? FACT_W'(w) : factor;
        br        = short_img ? FACT_W'(h) : factor;
        w_sh      = w >> lvl;
        h_sh      = h >> lvl;
        ow        = (w_sh == '0) ? DIM_W'(1) : w_sh;
        oh        = (h_sh == '0) ? DIM_W'(1) : h_sh;

        col_x = DIM_W'(r_col);
        row_x = DIM_W'(r_row);
        // narrow image: one block column, W wide
        oc    = narrow ? '0 : (col_x >> lvl);
        c     = narrow ? col_x : (col_x & mask_x);
        // short image: one band, H high
        band  = short_img ? '0 : (row_x >> lvl);
        r     = short_img ? row_x : (row_x & mask_x);

        in_block  = (oc < ow) && (band < oh) && (c < DIM_W'(bw)) && (r < DIM_W'(br));
        blk_first = (r == '0) && (c == '0);
        blk_last  = (r == DIM_W'(br) - DIM_W'(1)) && (c == DIM_W'(bw) - DIM_W'(1));
        blk_fend  = (oc == ow - DIM_W'(1)) && (band == oh - DIM_W'(1));
        div       = DIV_W'(bw) * DIV_W'(br);

        col_inc = col_x + DIM_W'(1);
        row_inc = row_x + DIM_W'(1);
    end

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    // lane control; the read is launched in the accept cycle
    always_comb begin
        ctl.addr  = (r_state == S_IDLE) ? COL_W'(oc) : r_oc;
        ctl.wr    = (r_state == S_ADD);
        ctl.first = r_first;
        ctl.step  = (r_state == S_DIV);
        ctl.dsh   = r_dsh;
    end

    assign push_load = (r_state == S_PUSH) && push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= LVL_W'(1);
            r_width  <= DIM_W'(4096);
            r_height <= DIM_W'(4096);
            r_nch    <= NCH_W'(4);
            r_col    <= '0;
            r_row    <= '0;
            r_state  <= S_IDLE;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEVEL:  r_level  <= i_cfg_data[LVL_W-1:0];
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    CFG_NCH:    r_nch    <= i_cfg_data[NCH_W-1:0];
                    default:    ;
                endcase
                // any write restarts the frame
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (col_inc >= w) begin
                    r_col <= '0;
                    r_row <= (row_inc >= h) ? '0 : ROW_W'(row_inc);
                end else begin
                    r_col <= COL_W'(col_inc);
                end
            end

            case (r_state)
                S_IDLE: begin
                    // leftover pixels only move the position
                    if (accept && in_block) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_cnt   <= '0;
                    r_state <= r_last ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(QW - 1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (push_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item payload, divisor aligned to the top quotient bit
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_oc     <= COL_W'(oc);
            r_first  <= blk_first;
            r_last   <= blk_last;
            r_fend   <= blk_fend;
            r_narrow <= narrow;
            r_dsh    <= SUM_W'(32'(div) << (QW - 1));
            r_pix    <= i_pix;
        end else if (r_state == S_DIV) begin
            r_dsh    <= r_dsh >> 1;
        end
    end

    assign pix_bytes[0] = r_pix.chan0;
    assign pix_bytes[1] = r_pix.chan1;
    assign pix_bytes[2] = r_pix.chan2;
    assign pix_bytes[3] = r_pix.chan3;

    // one lane per channel, each with its own column-sum store
    for (genvar g = 0; g < 4; g++) begin : g_lane
        if (g < MAX_CHANNELS) begin : g_used
            bfm_lane u_lane (
                .i_clk  (i_clk),
                .i_ctl  (ctl),
                .i_en   (NCH_W'(g) < nch),
                .i_byte (pix_bytes[g]),
                .o_q    (q_all[g])
            );
        end else begin : g_none
            assign q_all[g] = 8'd0;
        end
    end

    bfm_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (push_load),
        .i_q      (q_all),
        .i_nch    (nch),
        .i_fend   (r_fend),
        .i_narrow (r_narrow),
        .i_stall  (i_stall),
        .o_ready  (push_ready),
        .o_valid  (o_valid),
        .o_res    (o_res)
    );

endmodule

[rtl/core/bfm_ram.sv]
module bfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/bfm_lane.sv]
module bfm_lane (
    input  logic               i_clk,
    input  bfm_pkg::t_lane_ctl i_ctl,
    input  logic               i_en,
    input  logic [7:0]         i_byte,
    output logic [7:0]         o_q
);
    import bfm_pkg::*;

    logic [SUM_W-1:0] ram_rdata;
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0] r_rem;
    logic [QW-1:0]    r_q;

    // new column sum: top-left pixel of a block overwrites
    assign n_sum = i_ctl.first ? SUM_W'(i_byte) : ram_rdata + SUM_W'(i_byte);

    bfm_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr && i_en),
        .i_addr  (i_ctl.addr),
        .i_wdata (n_sum),
        .o_rdata (ram_rdata)
    );

    // restoring divide, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_rem <= n_sum;
            r_q   <= '0;
        end else if (i_ctl.step) begin
            if (r_rem >= i_ctl.dsh) begin
                r_rem <= r_rem - i_ctl.dsh;
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
        end
    end

    assign o_q = r_q;

endmodule

[rtl/core/bfm_merge.sv]
module bfm_merge (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [7:0]             i_q [4],
    input  logic [bfm_pkg::NCH_W-1:0] i_nch,
    input  logic                   i_fend,
    input  logic                   i_narrow,
    input  logic                   i_stall,
    output logic                   o_ready,
    output logic                   o_valid,
    output bfm_pkg::t_pix_out      o_res
);
    import bfm_pkg::*;

    logic     r_valid;
    t_pix_out r_res;
    logic [7:0] avg [4];

    // unused channels read as zero
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            avg[k] = (NCH_W'(k) < i_nch) ? i_q[k] : 8'd0;
        end
    end

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res.avg0        <= avg[0];
            r_res.avg1        <= avg[1];
            r_res.avg2        <= avg[2];
            r_res.avg3        <= avg[3];
            r_res.frame_end   <= i_fend;
            r_res.width_error <= i_narrow;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
